// ===== rtl/core/scheduled_thermostat_defines.svh =====
// Assertion macros shared by the thermostat RTL.
// Expects i_clk and i_rst_n in the including module; no other dependencies.
`ifndef SCHEDULED_THERMOSTAT_DEFINES_SVH
`define SCHEDULED_THERMOSTAT_DEFINES_SVH

// same-cycle implication
`define ST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sthermo_pkg.sv =====
// Shared types and constants for the scheduled thermostat.
// Used by sthermo_seq, sthermo_dp and scheduled_thermostat; no dependencies.
package sthermo_pkg;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_START,
        OP_BUTTON,
        OP_RD_SCAN,
        OP_CMP,
        OP_RD_CUR,
        OP_LOAD,
        OP_HEAT,
        OP_WRITE,
        OP_EMIT
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_WRITE,
        C_NOTDONE,
        C_BUSY
    } t_cond;

    // microprogram addresses
    typedef enum logic [3:0] {
        ST_WAIT   = 4'd0,
        ST_DISP   = 4'd1,
        ST_BTN    = 4'd2,
        ST_RDSCAN = 4'd3,
        ST_CMP    = 4'd4,
        ST_RDCUR  = 4'd5,
        ST_LOAD   = 4'd6,
        ST_HEAT   = 4'd7,
        ST_WRITE  = 4'd8,
        ST_EMIT   = 4'd9,
        ST_DONE   = 4'd10
    } t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic start;
        logic is_write;
        logic scan_done;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        logic               req_type;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic signed [11:0] temperature;
        logic [31:0]        now_ms;
        logic [3:0]         buttons;
        logic [3:0]         entry_index;
        logic [4:0]         entry_hour;
        logic [5:0]         entry_minute;
        logic [7:0]         entry_setpoint;
    } t_item;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] setpoint;
    } t_entry;

    typedef struct packed {
        logic       heater_drive;
        logic [7:0] current_setpoint;
        logic [3:0] active_program;
        logic       manual_off;
        logic       program_changed;
    } t_result;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PROG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON_MS  = 2'd2;

    localparam logic [3:0] BTN_TOGGLE = 4'd1;
    localparam logic [3:0] BTN_DOWN   = 4'd2;
    localparam logic [3:0] BTN_UP     = 4'd4;

    localparam logic [4:0]  PROG_COUNT_RST = 5'd4;
    localparam logic [7:0]  DEADBAND_RST   = 8'd4;
    localparam logic [31:0] MIN_ON_RST     = 32'd300000;
    localparam logic [7:0]  SETPOINT_RST   = 8'd18;
    localparam logic [7:0]  SETPOINT_MAX   = 8'd255;
    localparam logic [10:0] MIN_PER_HOUR   = 11'd60;

endpackage

// ===== rtl/core/sthermo_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on sthermo_pkg.
module sthermo_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sthermo_pkg::t_flags  i_flags,
    output sthermo_pkg::t_uword  o_uword
);

    sthermo_pkg::t_step  r_step;
    sthermo_pkg::t_step  n_step;
    sthermo_pkg::t_uword uword;
    logic                take;

    function automatic sthermo_pkg::t_uword rom(input sthermo_pkg::t_step s);
        sthermo_pkg::t_uword w;
        w = '{op: sthermo_pkg::OP_NOP, cond: sthermo_pkg::C_ALWAYS,
              target: sthermo_pkg::ST_WAIT};
        case (s)
            sthermo_pkg::ST_WAIT:   w = '{sthermo_pkg::OP_WAIT, sthermo_pkg::C_NOSTART,
                                          sthermo_pkg::ST_WAIT};
            sthermo_pkg::ST_DISP:   w = '{sthermo_pkg::OP_START, sthermo_pkg::C_WRITE,
                                          sthermo_pkg::ST_WRITE};
            sthermo_pkg::ST_BTN:    w = '{sthermo_pkg::OP_BUTTON, sthermo_pkg::C_NEVER,
                                          sthermo_pkg::ST_WAIT};
            sthermo_pkg::ST_RDSCAN: w = '{sthermo_pkg::OP_RD_SCAN, sthermo_pkg::C_NEVER,
                                          sthermo_pkg::ST_WAIT};
            sthermo_pkg::ST_CMP:    w = '{sthermo_pkg::OP_CMP, sthermo_pkg::C_NOTDONE,
                                          sthermo_pkg::ST_RDSCAN};
            sthermo_pkg::ST_RDCUR:  w = '{sthermo_pkg::OP_RD_CUR, sthermo_pkg::C_NEVER,
                                          sthermo_pkg::ST_WAIT};
            sthermo_pkg::ST_LOAD:   w = '{sthermo_pkg::OP_LOAD, sthermo_pkg::C_NEVER,
                                          sthermo_pkg::ST_WAIT};
            sthermo_pkg::ST_HEAT:   w = '{sthermo_pkg::OP_HEAT, sthermo_pkg::C_ALWAYS,
                                          sthermo_pkg::ST_EMIT};
            sthermo_pkg::ST_WRITE:  w = '{sthermo_pkg::OP_WRITE, sthermo_pkg::C_NEVER,
                                          sthermo_pkg::ST_WAIT};
            sthermo_pkg::ST_EMIT:   w = '{sthermo_pkg::OP_EMIT, sthermo_pkg::C_BUSY,
                                          sthermo_pkg::ST_EMIT};
            sthermo_pkg::ST_DONE:   w = '{sthermo_pkg::OP_NOP, sthermo_pkg::C_ALWAYS,
                                          sthermo_pkg::ST_WAIT};
            default:                w = '{sthermo_pkg::OP_NOP, sthermo_pkg::C_ALWAYS,
                                          sthermo_pkg::ST_WAIT};
        endcase
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sthermo_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uword = rom(r_step);
        case (uword.cond)
            sthermo_pkg::C_NEVER:   take = 1'b0;
            sthermo_pkg::C_ALWAYS:  take = 1'b1;
            sthermo_pkg::C_NOSTART: take = !i_flags.start;
            sthermo_pkg::C_WRITE:   take = i_flags.is_write;
            sthermo_pkg::C_NOTDONE: take = !i_flags.scan_done;
            sthermo_pkg::C_BUSY:    take = i_flags.out_busy;
            default:                take = 1'b1;
        endcase
        n_step = take ? uword.target : sthermo_pkg::t_step'(r_step + 4'd1);
    end

    assign o_uword = uword;

endmodule

// ===== rtl/core/sthermo_dp.sv =====
// Thermostat datapath: schedule memory, scan index, setpoint and heater state.
// Depends on sthermo_pkg and scheduled_thermostat_defines.svh.
`include "scheduled_thermostat_defines.svh"

module sthermo_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sthermo_pkg::t_op      i_op,
    input  sthermo_pkg::t_item    i_item,
    input  logic [4:0]            i_prog_count,
    input  logic [7:0]            i_deadband,
    input  logic [31:0]           i_min_on_ms,
    output logic                  o_scan_done,
    output sthermo_pkg::t_result  o_result
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    sthermo_pkg::t_entry r_mem [MAX_ENTRIES];
    sthermo_pkg::t_entry r_rd;
    sthermo_pkg::t_entry wr_entry;

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_last_prog;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_ok;
    logic          r_last_valid;
    logic          r_changed;
    logic          r_off;
    logic          r_heater;
    logic [7:0]    r_setpoint;
    logic [31:0]   r_on_stamp;

    logic [10:0]        now_min;
    logic [10:0]        start_min;
    logic signed [13:0] sp16;
    logic signed [13:0] shortfall;
    logic               heat_req;
    logic [31:0]        elapsed;

    // clamp prog_count to 1..MAX_ENTRIES, kept as the index of the last entry
    always_comb begin
        if (i_prog_count == 5'd0) begin
            last_idx = '0;
        end else if ({3'b000, i_prog_count} > 8'(MAX_ENTRIES)) begin
            last_idx = IW'(MAX_ENTRIES - 1);
        end else begin
            last_idx = IW'(i_prog_count - 5'd1);
        end
    end

    assign wr_addr  = IW'(i_item.entry_index);
    assign wr_ok    = {4'b0000, i_item.entry_index} < 8'(MAX_ENTRIES);
    assign wr_entry = '{hour: i_item.entry_hour, minute: i_item.entry_minute,
                        setpoint: i_item.entry_setpoint};
    assign rd_addr  = (i_op == sthermo_pkg::OP_RD_CUR) ? r_cur : r_idx;

    assign now_min   = 11'(i_item.hour) * sthermo_pkg::MIN_PER_HOUR + 11'(i_item.minute);
    assign start_min = 11'(r_rd.hour) * sthermo_pkg::MIN_PER_HOUR + 11'(r_rd.minute);
    assign o_scan_done = (now_min < start_min) || (r_idx == last_idx);

    assign sp16      = $signed({2'b00, r_setpoint, 4'b0000});
    assign shortfall = sp16 - 14'(i_item.temperature);
    assign heat_req  = shortfall > $signed({6'b000000, i_deadband});
    assign elapsed   = i_item.now_ms - r_on_stamp;

    // schedule memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_op == sthermo_pkg::OP_WRITE && wr_ok) begin
            r_mem[wr_addr] <= wr_entry;
        end
        if (i_op == sthermo_pkg::OP_RD_SCAN || i_op == sthermo_pkg::OP_RD_CUR) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // scan pointers
    always_ff @(posedge i_clk) begin
        case (i_op)
            sthermo_pkg::OP_BUTTON: begin
                r_idx <= '0;
                r_cur <= last_idx;
            end
            sthermo_pkg::OP_CMP: begin
                if (now_min >= start_min) begin
                    r_cur <= r_idx;
                end
                r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= sthermo_pkg::SETPOINT_RST;
            r_off        <= 1'b0;
            r_last_prog  <= '0;
            r_last_valid <= 1'b0;
            r_heater     <= 1'b0;
            r_on_stamp   <= '0;
            r_changed    <= 1'b0;
        end else begin
            case (i_op)
                sthermo_pkg::OP_START: begin
                    r_changed <= 1'b0;
                end
                sthermo_pkg::OP_BUTTON: begin
                    if (i_item.buttons == sthermo_pkg::BTN_TOGGLE) begin
                        if (!r_off) begin
                            r_off      <= 1'b1;
                            r_setpoint <= '0;
                        end else begin
                            r_off        <= 1'b0;
                            r_last_valid <= 1'b0;
                        end
                    end else if (i_item.buttons == sthermo_pkg::BTN_DOWN) begin
                        if (r_setpoint != '0) begin
                            r_setpoint <= r_setpoint - 8'd1;
                        end
                    end else if (i_item.buttons == sthermo_pkg::BTN_UP) begin
                        if (r_setpoint != sthermo_pkg::SETPOINT_MAX) begin
                            r_setpoint <= r_setpoint + 8'd1;
                        end
                    end
                end
                sthermo_pkg::OP_LOAD: begin
                    if (!r_last_valid || r_cur != r_last_prog) begin
                        r_setpoint   <= r_rd.setpoint;
                        r_last_prog  <= r_cur;
                        r_last_valid <= 1'b1;
                        r_changed    <= 1'b1;
                    end
                end
                sthermo_pkg::OP_HEAT: begin
                    if (heat_req) begin
                        if (!r_heater) begin
                            r_on_stamp <= i_item.now_ms;
                        end
                        r_heater <= 1'b1;
                    end else if (elapsed > i_min_on_ms) begin
                        r_heater <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result = '{heater_drive:     r_heater,
                        current_setpoint: r_setpoint,
                        active_program:   r_last_valid ? 4'(r_last_prog) : 4'd0,
                        manual_off:       r_off,
                        program_changed:  r_changed};

    `ST_ASSERT_NOW(a_stamp_on_rise, $rose(r_heater), r_on_stamp == i_item.now_ms, "on-stamp not taken at turn-on")
    `ST_ASSERT_NEXT(a_load_valid, i_op == sthermo_pkg::OP_LOAD, r_last_valid, "program not valid after load step")
    `ST_ASSERT_NOW(a_off_zero, $rose(r_off), r_setpoint == 8'd0, "manual-off entered with nonzero setpoint")

endmodule

// ===== rtl/core/scheduled_thermostat.sv =====
// A table write steps through WAIT, DISP, WRITE, EMIT and DONE; a tick through WAIT, DISP,
// BTN, then RDSCAN and CMP for each entry scanned (1..prog_count), then RDCUR, LOAD, HEAT,
// EMIT and DONE. One item at a time: the next word is taken only after the previous one has
// left DONE, later while a finished result still waits for i_m_tready. The scan reads one
// entry in each RDSCAN step. Reset (synchronous, active low): setpoint 18, heater off, no
// program selected, prog_count 4, deadband 4, min_on_ms 300000; schedule memory not cleared.
`include "scheduled_thermostat_defines.svh"

module scheduled_thermostat #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input words
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // hour[4:0] minute[10:5] temperature[22:11] now_ms[54:23] buttons[58:55]
    // entry_index[62:59] entry_hour[67:63] entry_minute[73:68] entry_setpoint[81:74]
    input  logic [sthermo_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // req_type[0]
    input  logic                                   i_s_tuser,
    // result words
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // heater_drive[0] current_setpoint[8:1] active_program[12:9] manual_off[13]
    // program_changed[14]
    output logic [sthermo_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sthermo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sthermo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    sthermo_pkg::t_item   r_item;
    sthermo_pkg::t_item   item_in;
    sthermo_pkg::t_result r_out;
    sthermo_pkg::t_result result;
    sthermo_pkg::t_uword  uword;
    sthermo_pkg::t_flags  flags;

    logic        r_out_valid;
    logic [4:0]  r_prog_count;
    logic [7:0]  r_deadband;
    logic [31:0] r_min_on_ms;
    logic        s_accept;
    logic        emit;
    logic        scan_done;

    assign item_in = '{req_type:       i_s_tuser,
                       hour:           i_s_tdata[4:0],
                       minute:         i_s_tdata[10:5],
                       temperature:    i_s_tdata[22:11],
                       now_ms:         i_s_tdata[54:23],
                       buttons:        i_s_tdata[58:55],
                       entry_index:    i_s_tdata[62:59],
                       entry_hour:     i_s_tdata[67:63],
                       entry_minute:   i_s_tdata[73:68],
                       entry_setpoint: i_s_tdata[81:74]};

    assign o_s_tready = (uword.op == sthermo_pkg::OP_WAIT);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign emit       = (uword.op == sthermo_pkg::OP_EMIT) && !flags.out_busy;

    assign flags = '{start:     s_accept,
                     is_write:  r_item.req_type,
                     scan_done: scan_done,
                     out_busy:  r_out_valid && !i_m_tready};

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= item_in;
        end
        if (emit) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_count <= sthermo_pkg::PROG_COUNT_RST;
            r_deadband   <= sthermo_pkg::DEADBAND_RST;
            r_min_on_ms  <= sthermo_pkg::MIN_ON_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sthermo_pkg::CFG_PROG_COUNT: r_prog_count <= i_cfg_data[4:0];
                sthermo_pkg::CFG_DEADBAND:   r_deadband   <= i_cfg_data[7:0];
                sthermo_pkg::CFG_MIN_ON_MS:  r_min_on_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sthermo_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword)
    );

    sthermo_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (uword.op),
        .i_item       (r_item),
        .i_prog_count (r_prog_count),
        .i_deadband   (r_deadband),
        .i_min_on_ms  (r_min_on_ms),
        .o_scan_done  (scan_done),
        .o_result     (result)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_out.program_changed,
                         r_out.manual_off,
                         r_out.active_program,
                         r_out.current_setpoint,
                         r_out.heater_drive};

    `ST_ASSERT_NEXT(a_accept_leaves_wait, s_accept, !o_s_tready, "input taken twice for one item")
    `ST_ASSERT_NOW(a_emit_free, emit, !r_out_valid || i_m_tready, "result written over a pending word")

endmodule
